// ===== rtl/core/sjrb_pkg.sv =====
// Shared constants, types and helpers for the stereo jitter ring buffer.
// No dependencies; imported by the front end, queue, back end and top level.
package sjrb_pkg;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned MAX_REQUEST = 64;
  localparam int unsigned CW          = 7;
  localparam int unsigned FW          = 13;
  localparam int unsigned SW          = 32;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QAW         = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [CW-1:0] real_cnt;
    logic [CW-1:0] total;
    logic [FW-1:0] fill;
    logic [SW-1:0] uf_total;
    logic [SW-1:0] of_total;
  } job_t;

  typedef struct packed {
    logic q_full;
    logic pending;
  } status_t;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sjrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sjrb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/sjrb_front.sv =====
// Front end: accepts commands, keeps pointers, fill level and counters,
// writes samples to the store and queues read and peek jobs. Uses sjrb_pkg.
module sjrb_front
  import sjrb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [SW-1:0]    left_in_i,
  input  logic [SW-1:0]    right_in_i,
  input  logic [CW-1:0]    count_i,
  input  status_t          status_i,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [2*SW-1:0]  mem_wdata_o,
  output logic             job_push_o,
  output job_t             job_o
);

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FW-1:0] held_q, held_d;
  logic [SW-1:0] uf_q, uf_d, of_q, of_d;
  cmd_e          cmd;
  logic          accept;
  logic [CW-1:0] n, avail;
  logic [AW:0]   rp_sum;

  assign cmd    = cmd_e'(cmd_i);
  assign accept = in_valid_i && !in_stall_o;
  assign n      = (count_i > CW'(MAX_REQUEST)) ? CW'(MAX_REQUEST) : count_i;
  assign avail  = ({{(FW-CW){1'b0}}, n} < held_q) ? n : held_q[CW-1:0];
  assign rp_sum = {1'b0, rp_q} + (AW+1)'(avail);

  always_comb begin
    unique case (cmd)
      CMD_WRITE: in_stall_o = status_i.pending;
      CMD_READ:  in_stall_o = status_i.q_full;
      CMD_PEEK:  in_stall_o = status_i.q_full;
      CMD_RESET: in_stall_o = 1'b0;
    endcase
  end

  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = {left_in_i, right_in_i};

  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    held_d     = held_q;
    uf_d       = uf_q;
    of_d       = of_q;
    mem_we_o   = 1'b0;
    job_push_o = 1'b0;
    job_o      = '0;
    if (accept) begin
      unique case (cmd)
        CMD_WRITE: begin
          mem_we_o = 1'b1;
          wp_d     = next_ptr(wp_q);
          if (held_q < FW'(DEPTH)) begin
            held_d = held_q + 1'b1;
          end else begin
            rp_d = next_ptr(rp_q);
            of_d = of_q + 1'b1;
          end
        end
        CMD_READ: begin
          if (n != '0) begin
            if (rp_sum >= (AW+1)'(DEPTH)) begin
              rp_d = AW'(rp_sum - (AW+1)'(DEPTH));
            end else begin
              rp_d = rp_sum[AW-1:0];
            end
            held_d = held_q - FW'(avail);
            if (avail < n) begin
              uf_d = uf_q + 1'b1;
            end
            job_push_o     = 1'b1;
            job_o.start    = rp_q;
            job_o.real_cnt = avail;
            job_o.total    = n;
            job_o.fill     = held_d;
            job_o.uf_total = uf_d;
            job_o.of_total = of_q;
          end
        end
        CMD_PEEK: begin
          if (avail != '0) begin
            job_push_o = 1'b1;
            if ({1'b0, wp_q} >= (AW+1)'(avail)) begin
              job_o.start = wp_q - AW'(avail);
            end else begin
              job_o.start = AW'({1'b0, wp_q} + (AW+1)'(DEPTH) - (AW+1)'(avail));
            end
            job_o.real_cnt = avail;
            job_o.total    = avail;
            job_o.fill     = held_q;
            job_o.uf_total = uf_q;
            job_o.of_total = of_q;
          end
        end
        CMD_RESET: begin
          wp_d   = '0;
          rp_d   = '0;
          held_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      held_q <= '0;
      uf_q   <= '0;
      of_q   <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      held_q <= held_d;
      uf_q   <= uf_d;
      of_q   <= of_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= FW'(DEPTH))
    else $error("fill level above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we_o |-> !status_i.pending)
    else $error("store written while a job is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push_o |-> !status_i.q_full)
    else $error("job pushed into full queue");

endmodule

// ===== rtl/core/sjrb_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Uses sjrb_pkg for the job type.
module sjrb_queue
  import sjrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t           entry_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sjrb_back.sv =====
// Back end: runs one job at a time, reads the store and streams results
// through a read stage and an output register. Uses sjrb_pkg.
module sjrb_back
  import sjrb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  job_t            q_job_i,
  output logic            q_pop_o,
  output logic            active_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [2*SW-1:0] mem_rdata_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [SW-1:0]   left_out_o,
  output logic [SW-1:0]   right_out_o,
  output logic            real_sample_o,
  output logic            last_o,
  output logic [FW-1:0]   fill_level_o,
  output logic [SW-1:0]   underflow_total_o,
  output logic [SW-1:0]   overflow_total_o
);

  job_t          job_q;
  logic          active_q;
  logic [CW-1:0] idx_q;
  logic [AW-1:0] ptr_q;

  logic          s1_v_q, s1_real_q, s1_last_q;
  logic [FW-1:0] s1_fill_q;
  logic [SW-1:0] s1_uf_q, s1_of_q;

  logic out_free, s1_move, s1_free, issue, is_real, is_last;

  assign out_free = !out_valid_o || !out_stall_i;
  assign s1_move  = s1_v_q && out_free;
  assign s1_free  = !s1_v_q || s1_move;
  assign issue    = active_q && s1_free;
  assign q_pop_o  = !active_q && !q_empty_i;
  assign active_o = active_q;
  assign is_real  = idx_q < job_q.real_cnt;
  assign is_last  = (idx_q + 1'b1) == job_q.total;

  assign mem_re_o    = issue;
  assign mem_raddr_o = ptr_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
      ptr_q <= q_job_i.start;
    end else if (issue && is_real) begin
      ptr_q <= next_ptr(ptr_q);
    end
    if (issue) begin
      s1_real_q <= is_real;
      s1_last_q <= is_last;
      s1_fill_q <= job_q.fill;
      s1_uf_q   <= job_q.uf_total;
      s1_of_q   <= job_q.of_total;
    end
    if (s1_move) begin
      left_out_o        <= s1_real_q ? mem_rdata_i[2*SW-1:SW] : '0;
      right_out_o       <= s1_real_q ? mem_rdata_i[SW-1:0] : '0;
      real_sample_o     <= s1_real_q;
      last_o            <= s1_last_q;
      fill_level_o      <= s1_fill_q;
      underflow_total_o <= s1_uf_q;
      overflow_total_o  <= s1_of_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      s1_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (q_pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
        if (is_last) begin
          active_q <= 1'b0;
        end
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (job_q.total != '0) && (job_q.real_cnt <= job_q.total))
    else $error("malformed job in back end");
  assert property (@(posedge clk_i) disable iff (!rst_ni) active_q |-> idx_q < job_q.total)
    else $error("result index past end of job");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_free |-> !mem_re_o ##1 s1_v_q)
    else $error("read stage overwritten while stalled");

endmodule

// ===== rtl/core/stereo_jitter_ring_buffer.sv =====
// Stereo jitter ring buffer: 4096 left/right sample pairs, overwriting when full.
// Input channel (in_valid_i/in_stall_o) takes write, read, peek and pointer-reset
// commands; output channel (out_valid_o/out_stall_i) gives one result per sample.
// A write stores a pair and gives no result; on a full buffer the
// oldest pair is dropped and the overflow total rises. A read of n (n capped
// at 64) gives n results, stored pairs first, then zero silence; a short read
// bumps the underflow total once. A peek gives the newest min(n, fill) pairs,
// oldest first. Read and peek jobs wait in a two-entry queue; the back end
// loads a job, then streams one result per cycle while out_stall_i is low.
// A write is held off until all queued jobs have read the store.
// Reset clears pointers, fill level, counters and all pending jobs; store
// contents are undefined until written. When out_stall_i is high while
// out_valid_o is high, the output and a full read stage hold, and the back
// end stops reading the store until the read stage can move on.
// Depends on sjrb_pkg, sjrb_front, sjrb_queue, sjrb_back and sjrb_ram.
module stereo_jitter_ring_buffer
  import sjrb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    cmd_i,
  input  logic [SW-1:0] left_in_i,
  input  logic [SW-1:0] right_in_i,
  input  logic [CW-1:0] count_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [SW-1:0] left_out_o,
  output logic [SW-1:0] right_out_o,
  output logic          real_sample_o,
  output logic          last_o,
  output logic [FW-1:0] fill_level_o,
  output logic [SW-1:0] underflow_total_o,
  output logic [SW-1:0] overflow_total_o
);

  status_t         status;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [2*SW-1:0] mem_wdata, mem_rdata;
  logic            job_push, job_pop, q_empty, q_full, back_active;
  job_t            job_in, job_out;

  assign status.q_full  = q_full;
  assign status.pending = !q_empty || back_active;

  sjrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .count_i     (count_i),
    .status_i    (status),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  sjrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sjrb_ram #(
    .WIDTH (2 * SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sjrb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_job_i           (job_out),
    .q_pop_o           (job_pop),
    .active_o          (back_active),
    .mem_re_o          (mem_re),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .left_out_o        (left_out_o),
    .right_out_o       (right_out_o),
    .real_sample_o     (real_sample_o),
    .last_o            (last_o),
    .fill_level_o      (fill_level_o),
    .underflow_total_o (underflow_total_o),
    .overflow_total_o  (overflow_total_o)
  );

endmodule
